// File: hdl/tcm_pkg.sv
// Shared types, constants and helpers for the transposed-convolution tile MAC.
// Used by the channel interfaces, the RAM, the MAC cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tcm_pkg;

	localparam int IN_CH_DEF  = 16;
	localparam int OUT_CH_DEF = 16;
	localparam int KSIZE_DEF  = 4;

	localparam int OP_W  = 2;
	localparam int IDX_W = 12;
	localparam int VAL_W = 16;
	localparam int CH_W  = 4;
	localparam int SUM_W = 48;
	localparam int PRD_W = 2 * VAL_W;

	localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
	localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
	localparam logic [OP_W-1:0] OP_TILE   = 2'd2;

	typedef struct packed {
		logic                    vld;
		logic                    first;
		logic                    last;
		logic signed [VAL_W-1:0] sample;
	} mac_strm_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

`default_nettype wire

// File: hdl/tcm_in_if.sv
// Input channel: one word carries an opcode, an index and a Q4.12 value.
// Depends on tcm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcm_in_if;
	logic                             valid;
	logic                             ready;
	logic [tcm_pkg::OP_W-1:0]         op;
	logic [tcm_pkg::IDX_W-1:0]        index;
	logic signed [tcm_pkg::VAL_W-1:0] value;

	modport source (output valid, output op, output index, output value, input ready);
	modport sink (input valid, input op, input index, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/tcm_out_if.sv
// Result channel: one word per output channel with its Q24.24 sum.
// Depends on tcm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcm_out_if;
	logic                             valid;
	logic                             ready;
	logic [tcm_pkg::CH_W-1:0]         channel;
	logic signed [tcm_pkg::SUM_W-1:0] sum;
	logic                             last;

	modport source (output valid, output channel, output sum, output last, input ready);
	modport sink (input valid, input channel, input sum, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/tcm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on tcm_pkg for the address width helper.
`timescale 1ns / 1ps
`default_nettype none

module tcm_ram #(
	parameter int WIDTH = tcm_pkg::VAL_W,
	parameter int DEPTH = tcm_pkg::IN_CH_DEF * tcm_pkg::KSIZE_DEF * tcm_pkg::KSIZE_DEF,
	localparam int AW = tcm_pkg::addr_bits(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/tcm_cell.sv
// One MAC cell of the chain: owns the kernels and bias of one output channel,
// accumulates the tile stream and passes the stream and results to its neighbors.
// Depends on tcm_pkg and tcm_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcm_cell #(
	parameter int TILE_LEN = tcm_pkg::IN_CH_DEF * tcm_pkg::KSIZE_DEF * tcm_pkg::KSIZE_DEF,
	localparam int TAW = tcm_pkg::addr_bits(TILE_LEN)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tcm_pkg::mac_strm_t               strm_in,
	input  wire logic [TAW-1:0]                   addr_in,
	output tcm_pkg::mac_strm_t                    strm_out,
	output logic [TAW-1:0]                        addr_out,
	input  wire logic                             w_we,
	input  wire logic [TAW-1:0]                   w_addr,
	input  wire logic [tcm_pkg::VAL_W-1:0]        w_data,
	input  wire logic                             b_we,
	input  wire logic [tcm_pkg::VAL_W-1:0]        b_data,
	input  wire logic                             load,
	input  wire logic                             shift,
	input  wire logic signed [tcm_pkg::SUM_W-1:0] sh_in,
	output logic signed [tcm_pkg::SUM_W-1:0]      sh_out,
	output logic                                  done
);

	localparam int SUM_W = tcm_pkg::SUM_W;
	localparam int VAL_W = tcm_pkg::VAL_W;
	localparam int PRD_W = tcm_pkg::PRD_W;

	tcm_pkg::mac_strm_t      strm_s1;
	logic [TAW-1:0]          addr_s1;
	logic [VAL_W-1:0]        w_rd;
	logic signed [VAL_W-1:0] w_val;
	logic signed [PRD_W-1:0] prod_s2;
	logic                    vld_s2;
	logic                    first_s2;
	logic                    last_s2;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] out_q;
	logic [VAL_W-1:0]        bias_q;
	logic                    done_q;

	tcm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TILE_LEN)
	) u_wram (
		.clk  (clk),
		.we   (w_we),
		.waddr(w_addr),
		.wdata(w_data),
		.raddr(addr_in),
		.rdata(w_rd)
	);

	assign w_val = w_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strm_s1.vld <= 1'b0;
			vld_s2      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			strm_s1 <= strm_in;
			vld_s2  <= strm_s1.vld;
			done_q  <= vld_s2 && last_s2;
		end
	end

	// The bias is aligned to Q24.24 when the first product of a tile arrives.
	assign base = first_s2 ? {{(SUM_W - VAL_W - 12){bias_q[VAL_W-1]}}, bias_q, 12'b0} : acc_q;

	always_ff @(posedge clk) begin
		addr_s1  <= addr_in;
		prod_s2  <= PRD_W'(strm_s1.sample) * PRD_W'(w_val);
		first_s2 <= strm_s1.first;
		last_s2  <= strm_s1.last;
		if (b_we) begin
			bias_q <= b_data;
		end
		if (vld_s2) begin
			acc_q <= base + SUM_W'(prod_s2);
		end
		if (load) begin
			out_q <= acc_q;
		end else if (shift) begin
			out_q <= sh_in;
		end
	end

	assign strm_out = strm_s1;
	assign addr_out = addr_s1;
	assign sh_out   = out_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: hdl/transposed_conv_tile_mac.sv
// Top level of the transposed-convolution tile MAC: command decode, tile store,
// sequencer and a chain of one MAC cell per output channel.
// Depends on tcm_pkg, tcm_in_if, tcm_out_if, tcm_ram and tcm_cell.
//
//   port  | dir | words                      | payload
//   din   | in  | weight, bias, tile element | op, index, value
//   dout  | out | one per output channel     | channel, sum, last
//
// A bias or tile element is written as it is accepted; a weight write passes its
// index through three decode stages before the owning cell's kernel RAM.
// The final tile element starts a sweep of the tile RAM, one sample a cycle,
// through the cell chain: dout.valid rises once the last cell has finished,
// and one word leaves per cycle as dout accepts.
// Reset clears only control state; all stores hold garbage until written.
// din is not ready while a weight decodes, a tile computes or results drain.
`timescale 1ns / 1ps
`default_nettype none

module transposed_conv_tile_mac #(
	parameter int IN_CH  = tcm_pkg::IN_CH_DEF,
	parameter int OUT_CH = tcm_pkg::OUT_CH_DEF,
	parameter int KSIZE  = tcm_pkg::KSIZE_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tcm_in_if.sink    din,
	tcm_out_if.source dout
);

	localparam int KK       = KSIZE * KSIZE;
	localparam int TILE_LEN = IN_CH * KK;
	localparam int W_LEN    = TILE_LEN * OUT_CH;
	localparam int DB       = OUT_CH * KK;
	localparam int TAW      = tcm_pkg::addr_bits(TILE_LEN);
	localparam int OCW      = tcm_pkg::addr_bits(OUT_CH);
	localparam int RW       = tcm_pkg::addr_bits(KK);
	localparam int IDX_W    = tcm_pkg::IDX_W;
	localparam int VAL_W    = tcm_pkg::VAL_W;
	localparam int SUM_W    = tcm_pkg::SUM_W;
	localparam logic [24:0] MK = 25'((1 << 24) / KK);
	localparam logic [24:0] MB = 25'((1 << 24) / DB);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DEC  = 5'b00010,
		ST_RUN  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic in_hs;
	logic out_hs;
	logic is_w;
	logic is_b;
	logic t_we;
	logic fire;
	logic cnt_end;

	logic [36:0] pk;
	logic [36:0] pb;

	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [VAL_W-1:0] val_s1;
	logic [IDX_W-1:0] qk0_s1;
	logic [IDX_W-1:0] qb0_s1;

	logic [23:0] rk_full;
	logic [23:0] rb_full;
	logic        k_corr;
	logic        b_corr;

	logic             v_s2;
	logic [IDX_W-1:0] qk_s2;
	logic [IDX_W-1:0] qb_s2;
	logic [RW-1:0]    rk_s2;
	logic [VAL_W-1:0] val_s2;

	logic [23:0] oc_full;
	logic [23:0] wa_full;

	logic             v_s3;
	logic [OCW-1:0]   oc_s3;
	logic [TAW-1:0]   wa_s3;
	logic [VAL_W-1:0] val_s3;

	logic [TAW-1:0]   cnt_q;
	logic [OCW-1:0]   ocnt_q;
	logic             tv_s1;
	logic             tf_s1;
	logic             tl_s1;
	logic [TAW-1:0]   ta_s1;
	logic [VAL_W-1:0] t_rd;

	tcm_pkg::mac_strm_t      strm [OUT_CH+1];
	logic [TAW-1:0]          addr [OUT_CH+1];
	logic signed [SUM_W-1:0] sh   [OUT_CH+1];
	logic [OUT_CH-1:0]       done_vec;
	logic                    load;

	assign in_hs   = din.valid && din.ready;
	assign out_hs  = dout.valid && dout.ready;
	assign is_w    = in_hs && (din.op == tcm_pkg::OP_WEIGHT) && (32'(din.index) < W_LEN);
	assign is_b    = in_hs && (din.op == tcm_pkg::OP_BIAS);
	assign t_we    = in_hs && (din.op == tcm_pkg::OP_TILE) && (32'(din.index) < TILE_LEN);
	assign fire    = t_we && (din.index == IDX_W'(TILE_LEN - 1));
	assign cnt_end = (cnt_q == TAW'(TILE_LEN - 1));
	assign load    = done_vec[OUT_CH-1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (is_w) begin
					state_d = ST_DEC;
				end else if (fire) begin
					state_d = ST_RUN;
				end
			end
			ST_DEC: begin
				if (v_s3) begin
					state_d = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (cnt_end) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (load) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_hs && dout.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			tv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= is_w;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			tv_s1   <= (state_q == ST_RUN);
		end
	end

	// Weight index split: quotients by KK and by OUT_CH*KK come from a
	// reciprocal multiply that is low by at most one, fixed in the next stage.
	assign pk = 37'(din.index) * 37'(MK);
	assign pb = 37'(din.index) * 37'(MB);

	assign rk_full = 24'(idx_s1) - 24'(qk0_s1) * 24'(KK);
	assign rb_full = 24'(idx_s1) - 24'(qb0_s1) * 24'(DB);
	assign k_corr  = (rk_full >= 24'(KK));
	assign b_corr  = (rb_full >= 24'(DB));

	// The kernel is stored mirrored in row and column, which reverses its flat order.
	assign oc_full = 24'(qk_s2) - 24'(qb_s2) * 24'(OUT_CH);
	assign wa_full = 24'(qb_s2) * 24'(KK) + 24'(KK - 1) - 24'(rk_s2);

	always_ff @(posedge clk) begin
		idx_s1 <= din.index;
		val_s1 <= din.value;
		qk0_s1 <= pk[35:24];
		qb0_s1 <= pb[35:24];

		qk_s2  <= qk0_s1 + IDX_W'(k_corr);
		qb_s2  <= qb0_s1 + IDX_W'(b_corr);
		rk_s2  <= k_corr ? RW'(rk_full - 24'(KK)) : RW'(rk_full);
		val_s2 <= val_s1;

		oc_s3  <= oc_full[OCW-1:0];
		wa_s3  <= wa_full[TAW-1:0];
		val_s3 <= val_s2;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cnt_q <= '0;
		end else if (state_q == ST_RUN) begin
			cnt_q <= cnt_q + TAW'(1);
		end
		if (load) begin
			ocnt_q <= '0;
		end else if (out_hs) begin
			ocnt_q <= ocnt_q + OCW'(1);
		end
		tf_s1 <= (cnt_q == '0);
		tl_s1 <= cnt_end;
		ta_s1 <= cnt_q;
	end

	tcm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TILE_LEN)
	) u_tile_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(din.index[TAW-1:0]),
		.wdata(din.value),
		.raddr(cnt_q),
		.rdata(t_rd)
	);

	assign strm[0] = '{vld: tv_s1, first: tf_s1, last: tl_s1, sample: t_rd};
	assign addr[0] = ta_s1;
	assign sh[OUT_CH] = '0;

	for (genvar j = 0; j < OUT_CH; j++) begin : g_cell
		tcm_cell #(
			.TILE_LEN(TILE_LEN)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.strm_in (strm[j]),
			.addr_in (addr[j]),
			.strm_out(strm[j+1]),
			.addr_out(addr[j+1]),
			.w_we    (v_s3 && (oc_s3 == OCW'(j))),
			.w_addr  (wa_s3),
			.w_data  (val_s3),
			.b_we    (is_b && (din.index == IDX_W'(j))),
			.b_data  (din.value),
			.load    (load),
			.shift   (out_hs),
			.sh_in   (sh[j+1]),
			.sh_out  (sh[j]),
			.done    (done_vec[j])
		);
	end

	assign din.ready    = (state_q == ST_IDLE);
	assign dout.valid   = (state_q == ST_OUT);
	assign dout.channel = tcm_pkg::CH_W'(ocnt_q);
	assign dout.sum     = sh[0];
	assign dout.last    = (ocnt_q == OCW'(OUT_CH - 1));

	// Cells finish one after another, never two in the same cycle.
	a_done_staggered: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(done_vec))
		else $error("two cells finished in the same cycle");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.ready && dout.last) |=> din.ready)
		else $error("input not ready after the final result");

	a_weight_channel: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (32'(oc_s3) < OUT_CH))
		else $error("decoded weight channel out of range");

	a_idle_chain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		din.ready |-> !strm[0].vld)
		else $error("tile stream active while accepting words");

endmodule

`default_nettype wire
